@@ rtl/core/dspf_pkg.sv @@
package dspf_pkg;

	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;
	localparam int PAT_SLOTS   = 16;
	localparam int PATTERN_W   = PAT_SLOTS * DIGIT_W;
	localparam int LENGTH_W    = 5;
	localparam int CFG_W       = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int POS_OUT_W   = 48;

	localparam int DEF_MAX_PATTERN    = 16;
	localparam int DEF_POSITION_WIDTH = 48;

	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_DIGITS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_KEEP_LEAD      = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	typedef logic [PATTERN_W-1:0] pattern_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	// row j, column m: the first m pattern digits equal the m digits ending before slot j
	typedef logic [PAT_SLOTS-1:0][PAT_SLOTS-1:0] overlap_t;

	function automatic overlap_t overlap_matrix(pattern_t p);
		logic [PAT_SLOTS-1:0][PAT_SLOTS-1:0] eq;
		overlap_t o;
		logic ok;
		int idx;
		for (int a = 0; a < PAT_SLOTS; a++) begin
			for (int b = 0; b < PAT_SLOTS; b++) begin
				eq[a][b] = (p[a*DIGIT_W +: DIGIT_W] == p[b*DIGIT_W +: DIGIT_W]);
			end
		end
		for (int j = 0; j < PAT_SLOTS; j++) begin
			for (int m = 0; m < PAT_SLOTS; m++) begin
				ok = (m <= j);
				for (int t = 0; t < PAT_SLOTS; t++) begin
					idx = j - m + t;
					if (idx < 0 || idx >= PAT_SLOTS) begin
						idx = 0;
					end
					if (t < m && !eq[t][idx]) begin
						ok = 1'b0;
					end
				end
				o[j][m] = ok;
			end
		end
		return o;
	endfunction

endpackage

@@ rtl/core/dspf_if.sv @@
interface dspf_char_if;
	logic                       valid;
	logic                       ready;
	logic [dspf_pkg::CHAR_W-1:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

interface dspf_result_if;
	logic                          valid;
	logic                          ready;
	logic                          match_now;
	logic                          finished;
	logic [dspf_pkg::POS_OUT_W-1:0] match_start;
	logic [dspf_pkg::POS_OUT_W-1:0] digits_counted;

	modport source (output valid, output match_now, output finished, output match_start,
		output digits_counted, input ready);
	modport sink (input valid, input match_now, input finished, input match_start,
		input digits_counted, output ready);
endinterface

@@ rtl/core/dspf_kmp_step.sv @@
module dspf_kmp_step #(
	parameter int MAX_PATTERN = dspf_pkg::DEF_MAX_PATTERN,
	parameter int PW          = $clog2(MAX_PATTERN + 1)
) (
	input  dspf_pkg::pattern_t              pattern,
	input  dspf_pkg::overlap_t              overlap,
	input  logic [PW-1:0]                   prefix,
	input  dspf_pkg::digit_t                digit,
	output logic [PW-1:0]                   prefix_next
);

	logic [dspf_pkg::DIGIT_W-1:0] row;

	assign row = dspf_pkg::DIGIT_W'(prefix);

	// longest pattern prefix that ends the text seen so far plus this digit
	always_comb begin
		prefix_next = '0;
		for (int k = 1; k <= MAX_PATTERN; k++) begin
			if (overlap[row][k-1] &&
				pattern[(k-1)*dspf_pkg::DIGIT_W +: dspf_pkg::DIGIT_W] == digit) begin
				prefix_next = PW'(k);
			end
		end
	end

endmodule

@@ rtl/core/digit_stream_pattern_finder.sv @@
// Digit stream pattern finder.
// Channel text carries one ASCII character per word; channel result returns
// exactly one word per character: match_now, finished, match_start and
// digits_counted. Non-digit characters are ignored, the first '.' marks the
// decimal point, and unless the lead-digit option is set the first digit before
// the point is skipped. Matching is Knuth-Morris-Pratt with the whole fallback
// resolved combinationally from a prefix overlap matrix that is rebuilt on the
// same edge as a pattern_digits write.
// Configuration is a plain write port (cfg_wen, cfg_index, cfg_data); the user must
// write it only while no character is in flight, which the block does not enforce.
// A character taken from text goes into the input register and its result word
// into the output register, where it is held. Throughput: one character per cycle
// while the receiver does not stall, set by the input register to result register step.
// Reset: pattern all zero, length one, no digits counted, skip of the integer
// digit armed; text.ready is high during reset, so a character can be taken
// at the first edge after reset is released.
// When the receiver stalls, the result word holds and one more character is
// taken into the input register; text.ready then drops until the stall clears.
module digit_stream_pattern_finder #(
	parameter int MAX_PATTERN    = dspf_pkg::DEF_MAX_PATTERN,
	parameter int POSITION_WIDTH = dspf_pkg::DEF_POSITION_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wen,
	input  logic [dspf_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [dspf_pkg::CFG_W-1:0]         cfg_data,
	dspf_char_if.sink                          text,
	dspf_result_if.source                      result
);

	localparam int PW = $clog2(MAX_PATTERN + 1);
	localparam int LW = dspf_pkg::LENGTH_W;
	localparam int OW = dspf_pkg::POS_OUT_W;

	dspf_pkg::pattern_t          pattern_q;
	logic [LW-1:0]               length_q;
	dspf_pkg::overlap_t          overlap_q;
	logic [PW-1:0]               prefix_q;
	logic [POSITION_WIDTH-1:0]   count_q;
	logic                        point_q;
	logic                        skip_q;
	logic                        found_q;
	logic [POSITION_WIDTH-1:0]   start_q;

	logic                        valid_s1;
	logic [dspf_pkg::CHAR_W-1:0] char_s1;

	logic                        out_valid_q;
	logic                        match_now_q;
	logic                        finished_q;
	logic [OW-1:0]               match_start_q;
	logic [OW-1:0]               digits_counted_q;

	logic                        advance;
	logic                        take;
	logic [PW-1:0]               n_eff;
	logic                        is_point;
	logic                        is_digit;
	logic                        skip_now;
	logic                        use_digit;
	dspf_pkg::digit_t            digit;
	logic [PW-1:0]               prefix_in;
	logic [PW-1:0]               prefix_step;
	logic                        hit;
	logic [POSITION_WIDTH-1:0]   count_inc;
	logic [POSITION_WIDTH-1:0]   count_n;
	logic [POSITION_WIDTH-1:0]   start_n;
	logic [PW-1:0]               prefix_n;
	logic                        point_n;
	logic                        skip_n;
	logic                        found_n;

	assign advance      = !out_valid_q || result.ready;
	assign take         = valid_s1 && advance;
	assign text.ready   = !valid_s1 || advance;

	assign result.valid          = out_valid_q;
	assign result.match_now      = match_now_q;
	assign result.finished       = finished_q;
	assign result.match_start    = match_start_q;
	assign result.digits_counted = digits_counted_q;

	always_comb begin
		if (length_q == '0) begin
			n_eff = PW'(1);
		end else if (length_q > LW'(MAX_PATTERN)) begin
			n_eff = PW'(MAX_PATTERN);
		end else begin
			n_eff = PW'(length_q);
		end
	end

	assign is_point  = (char_s1 == dspf_pkg::CHAR_POINT);
	assign is_digit  = (char_s1 >= dspf_pkg::CHAR_ZERO) && (char_s1 <= dspf_pkg::CHAR_NINE);
	assign digit     = dspf_pkg::DIGIT_W'(char_s1 - dspf_pkg::CHAR_ZERO);
	assign skip_now  = !found_q && is_digit && !point_q && skip_q;
	assign use_digit = !found_q && is_digit && !(!point_q && skip_q);
	assign prefix_in = (prefix_q >= n_eff) ? '0 : prefix_q;

	dspf_kmp_step #(
		.MAX_PATTERN (MAX_PATTERN),
		.PW          (PW)
	) u_step (
		.pattern     (pattern_q),
		.overlap     (overlap_q),
		.prefix      (prefix_in),
		.digit       (digit),
		.prefix_next (prefix_step)
	);

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign hit       = use_digit && (prefix_step >= n_eff);

	always_comb begin
		point_n  = point_q;
		skip_n   = skip_q;
		count_n  = count_q;
		prefix_n = prefix_q;
		found_n  = found_q;
		start_n  = start_q;
		if (!found_q && is_point && !point_q) begin
			point_n = 1'b1;
		end
		if (skip_now) begin
			skip_n = 1'b0;
		end
		if (use_digit) begin
			count_n  = count_inc;
			prefix_n = hit ? '0 : prefix_step;
		end
		if (hit) begin
			found_n = 1'b1;
			start_n = count_inc - POSITION_WIDTH'(n_eff) + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q        <= '0;
			length_q         <= LW'(1);
			overlap_q        <= dspf_pkg::overlap_matrix('0);
			prefix_q         <= '0;
			count_q          <= '0;
			point_q          <= 1'b0;
			skip_q           <= 1'b1;
			found_q          <= 1'b0;
			start_q          <= '0;
			valid_s1         <= 1'b0;
			char_s1          <= '0;
			out_valid_q      <= 1'b0;
			match_now_q      <= 1'b0;
			finished_q       <= 1'b0;
			match_start_q    <= '0;
			digits_counted_q <= '0;
		end else begin
			if (text.valid && text.ready) begin
				valid_s1 <= 1'b1;
				char_s1  <= text.char_code;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end

			if (take) begin
				point_q          <= point_n;
				skip_q           <= skip_n;
				count_q          <= count_n;
				prefix_q         <= prefix_n;
				found_q          <= found_n;
				start_q          <= start_n;
				out_valid_q      <= 1'b1;
				match_now_q      <= hit;
				finished_q       <= found_n;
				match_start_q    <= found_n ? OW'(start_n) : '0;
				digits_counted_q <= OW'(count_n);
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wen) begin
				case (cfg_index)
					dspf_pkg::REG_PATTERN_DIGITS: begin
						pattern_q <= cfg_data;
						overlap_q <= dspf_pkg::overlap_matrix(cfg_data);
						prefix_q  <= '0;
					end
					dspf_pkg::REG_PATTERN_LENGTH: begin
						length_q <= cfg_data[LW-1:0];
						prefix_q <= '0;
					end
					dspf_pkg::REG_KEEP_LEAD: begin
						if (!point_q && count_q == '0) begin
							skip_q <= !cfg_data[0];
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
